// File: rtl/core/blr_pkg.sv
// Shared types and constants of the Bresenham line rasterizer.
`default_nettype none

package blr_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] x_start;
        logic [7:0] y_start;
        logic [7:0] x_end;
        logic [7:0] y_end;
        logic       ink;
    } t_blr_in;

    typedef struct packed {
        logic       pixel_valid;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic       pixel_ink;
        logic       on_screen;
        logic [9:0] byte_index;
        logic [2:0] bit_position;
        logic       last;
    } t_blr_out;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_blr_state;

    typedef struct packed {
        logic take;
        logic emit;
    } t_blr_cmd;

endpackage

`default_nettype wire

// File: rtl/core/blr_if.sv
// Valid/ready channel interfaces for the rasterizer command and pixel beats.
`default_nettype none

interface blr_in_if;
    import blr_pkg::*;
    logic    valid;
    logic    ready;
    t_blr_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface blr_out_if;
    import blr_pkg::*;
    logic     valid;
    logic     ready;
    t_blr_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bresenham_line_rasterizer_core.sv
// Bresenham line rasterizer: command beats in, one pixel beat out per command.
//
// Channels: i_in carries command beats (op start with endpoints and ink, or op
// step); o_out carries one result beat per command with the pixel, its
// on-screen flag and its page-organized frame buffer byte index and bit.
// A command accepted in the idle state moves the controller to the emit
// state, which loads its result into the output register once the output is
// free; a new command is not taken until that result is loaded. The controller
// takes a command in its idle state and loads the output register in the next
// state, so the state update and the address multiply sit in separate cycles.
// The output register parts the channels: a new command is taken while the
// previous result still waits. A stalled receiver holds the result beat
// stable and the controller waits before loading the next one.
// A step with no line in progress returns a beat with all fields zero.
// Reset: synchronous, active low; clears the line state and drops any
// pending result.
`default_nettype none

module bresenham_line_rasterizer_core #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    blr_in_if.sink     i_in,
    blr_out_if.source  o_out
);
    import blr_pkg::*;

    t_blr_cmd w_cmd;
    logic     w_in_ready;
    logic     w_out_valid;
    t_blr_out w_out_data;

    blr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    blr_datapath #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_data  (i_in.data),
        .o_out_data (w_out_data)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_out_data;

endmodule

`default_nettype wire

// File: rtl/core/blr_ctrl.sv
// Controller state machine: accepts command beats and schedules result beats.
`default_nettype none

module blr_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire               i_out_ready,
    output logic              o_out_valid,
    output blr_pkg::t_blr_cmd o_cmd
);
    import blr_pkg::*;

    t_blr_state r_state;
    t_blr_state n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd.take = i_in_valid && (r_state == S_IDLE);
        o_cmd.emit = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
        n_state    = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.take) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (o_cmd.emit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: rtl/core/blr_datapath.sv
// Datapath: line state, Bresenham step and frame buffer address of each pixel.
`default_nettype none

module blr_datapath #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire blr_pkg::t_blr_cmd i_cmd,
    input  wire blr_pkg::t_blr_in  i_in_data,
    output blr_pkg::t_blr_out      o_out_data
);
    import blr_pkg::*;

    localparam logic [8:0] LP_W = 9'(DISPLAY_WIDTH);
    localparam logic [8:0] LP_H = 9'(DISPLAY_HEIGHT);

    logic [7:0] r_cur_x, r_cur_y, r_end_x, r_end_y, r_dx, r_dy;
    logic       r_sx_neg, r_sy_neg, r_ink, r_active, r_blank;
    logic [9:0] r_err;
    t_blr_out   r_out;

    logic [7:0] n_cur_x, n_cur_y, n_end_x, n_end_y, n_dx, n_dy;
    logic       n_sx_neg, n_sy_neg, n_ink, n_active, n_blank;
    logic [9:0] n_err;

    logic signed [10:0] w_e2, w_neg_dy, w_dx11;
    logic               w_mx, w_my;
    logic               w_on;
    logic [13:0]        w_prod;
    logic [13:0]        w_addr;
    logic               w_x_lt, w_y_lt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_end_x  <= '0;
            r_end_y  <= '0;
            r_dx     <= '0;
            r_dy     <= '0;
            r_sx_neg <= 1'b0;
            r_sy_neg <= 1'b0;
            r_err    <= '0;
            r_ink    <= 1'b0;
            r_active <= 1'b0;
            r_blank  <= 1'b0;
        end else if (i_cmd.take) begin
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_end_x  <= n_end_x;
            r_end_y  <= n_end_y;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_sx_neg <= n_sx_neg;
            r_sy_neg <= n_sy_neg;
            r_err    <= n_err;
            r_ink    <= n_ink;
            r_active <= n_active;
            r_blank  <= n_blank;
        end
    end

    always_comb begin
        w_e2     = {r_err, 1'b0};
        w_neg_dy = -$signed({3'b000, r_dy});
        w_dx11   = $signed({3'b000, r_dx});
        w_mx     = (w_e2 > w_neg_dy);
        w_my     = (w_e2 < w_dx11);
        w_x_lt   = (i_in_data.x_start < i_in_data.x_end);
        w_y_lt   = (i_in_data.y_start < i_in_data.y_end);

        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_end_x  = r_end_x;
        n_end_y  = r_end_y;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_sx_neg = r_sx_neg;
        n_sy_neg = r_sy_neg;
        n_err    = r_err;
        n_ink    = r_ink;
        n_blank  = 1'b0;

        if (i_in_data.op == OP_START) begin
            n_cur_x  = i_in_data.x_start;
            n_cur_y  = i_in_data.y_start;
            n_end_x  = i_in_data.x_end;
            n_end_y  = i_in_data.y_end;
            n_ink    = i_in_data.ink;
            n_dx     = w_x_lt ? (i_in_data.x_end - i_in_data.x_start)
                              : (i_in_data.x_start - i_in_data.x_end);
            n_dy     = w_y_lt ? (i_in_data.y_end - i_in_data.y_start)
                              : (i_in_data.y_start - i_in_data.y_end);
            n_sx_neg = !w_x_lt;
            n_sy_neg = !w_y_lt;
            n_err    = {2'b00, n_dx} - {2'b00, n_dy};
        end else if (!r_active) begin
            n_blank = 1'b1;
        end else begin
            n_err = r_err - (w_mx ? {2'b00, r_dy} : 10'd0)
                          + (w_my ? {2'b00, r_dx} : 10'd0);
            if (w_mx) begin
                n_cur_x = r_sx_neg ? (r_cur_x - 8'd1) : (r_cur_x + 8'd1);
            end
            if (w_my) begin
                n_cur_y = r_sy_neg ? (r_cur_y - 8'd1) : (r_cur_y + 8'd1);
            end
        end

        if (n_blank) begin
            n_active = r_active;
        end else begin
            n_active = !((n_cur_x == n_end_x) && (n_cur_y == n_end_y));
        end
    end

    always_comb begin
        w_on   = ({1'b0, r_cur_x} < LP_W) && ({1'b0, r_cur_y} < LP_H);
        w_prod = {9'b0, r_cur_y[7:3]} * {5'b0, LP_W};
        w_addr = w_prod + {6'b0, r_cur_x};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_blank) begin
                r_out <= '0;
            end else begin
                r_out.pixel_valid  <= 1'b1;
                r_out.pixel_x      <= r_cur_x;
                r_out.pixel_y      <= r_cur_y;
                r_out.pixel_ink    <= r_ink;
                r_out.on_screen    <= w_on;
                r_out.byte_index   <= w_on ? w_addr[9:0] : 10'd0;
                r_out.bit_position <= w_on ? r_cur_y[2:0] : 3'd0;
                r_out.last         <= (r_cur_x == r_end_x) && (r_cur_y == r_end_y);
            end
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

// File: rtl/core/blr_checker.sv
// Port-level checker for the rasterizer result channel, bound to the top level.
`default_nettype none

module blr_checker (
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    i_out_valid,
    input wire                    i_out_ready,
    input wire blr_pkg::t_blr_out i_out_data
);
    import blr_pkg::*;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result beat dropped or changed while stalled");

    a_blank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.pixel_valid |-> i_out_data == '0)
        else $error("invalid pixel beat carries nonzero fields");

    a_clip_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.on_screen |->
            i_out_data.byte_index == 10'd0 && i_out_data.bit_position == 3'd0)
        else $error("clipped pixel carries a frame buffer address");

    a_bit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.on_screen |->
            i_out_data.pixel_valid && i_out_data.bit_position == i_out_data.pixel_y[2:0])
        else $error("bit position does not match pixel row");

endmodule

bind bresenham_line_rasterizer_core blr_checker u_blr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire

// File: verif/bresenham_line_rasterizer_core_test.sv
// Self-checking testbench of the Bresenham line rasterizer core.
`default_nettype none

module bresenham_line_rasterizer_core_test;
    import blr_pkg::*;

    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int NUM_ROWS       = 25;
    localparam int TOTAL_ITEMS    = 1075;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        t_blr_in  cmd;
        logic     typed;
        t_blr_out want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    blr_in_if  in_if ();
    blr_out_if out_if ();

    bresenham_line_rasterizer_core #(
        .DISPLAY_WIDTH (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always #5 i_clk = ~i_clk;

    int cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
    end

    initial begin
        wait (cycles == CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // line state of the predictor
    logic [7:0]        ln_x, ln_y, ln_end_x, ln_end_y, ln_dx, ln_dy;
    logic              ln_x_neg, ln_y_neg, ln_ink;
    logic              ln_active = 1'b0;
    logic signed [9:0] ln_err;

    t_blr_out pending_pixels[$];
    int  sent = 0;
    int  lines_started = 0;
    int  pixels_seen = 0;
    int  line_ends = 0;
    int  clipped = 0;
    int  idle_steps = 0;
    int  failures = 0;
    bit  calm = 1'b0;

    function automatic t_blr_out next_pixel(input t_blr_in cmd);
        t_blr_out px;
        int       e2;
        int       addr;
        logic     at_end;
        px = '0;
        if (cmd.op == OP_START) begin
            ln_x     = cmd.x_start;
            ln_y     = cmd.y_start;
            ln_end_x = cmd.x_end;
            ln_end_y = cmd.y_end;
            ln_ink   = cmd.ink;
            ln_x_neg = !(cmd.x_start < cmd.x_end);
            ln_y_neg = !(cmd.y_start < cmd.y_end);
            ln_dx    = ln_x_neg ? cmd.x_start - cmd.x_end : cmd.x_end - cmd.x_start;
            ln_dy    = ln_y_neg ? cmd.y_start - cmd.y_end : cmd.y_end - cmd.y_start;
            ln_err   = 10'(int'(ln_dx) - int'(ln_dy));
        end else begin
            if (!ln_active) begin
                return px;
            end
            e2 = 2 * int'(ln_err);
            if (e2 > -int'(ln_dy)) begin
                ln_err = 10'(int'(ln_err) - int'(ln_dy));
                ln_x   = ln_x_neg ? ln_x - 8'd1 : ln_x + 8'd1;
            end
            if (e2 < int'(ln_dx)) begin
                ln_err = 10'(int'(ln_err) + int'(ln_dx));
                ln_y   = ln_y_neg ? ln_y - 8'd1 : ln_y + 8'd1;
            end
        end
        at_end    = (ln_x == ln_end_x) && (ln_y == ln_end_y);
        ln_active = !at_end;
        px.pixel_valid = 1'b1;
        px.pixel_x     = ln_x;
        px.pixel_y     = ln_y;
        px.pixel_ink   = ln_ink;
        px.on_screen   = (int'(ln_x) < DISPLAY_WIDTH) && (int'(ln_y) < DISPLAY_HEIGHT);
        if (px.on_screen) begin
            addr = int'(ln_x) + (int'(ln_y) / 8) * DISPLAY_WIDTH;
            px.byte_index   = addr[9:0];
            px.bit_position = ln_y[2:0];
        end
        px.last = at_end;
        return px;
    endfunction

    function automatic t_blr_in rand_cmd();
        logic [63:0] r;
        t_blr_in     cmd;
        r   = {$urandom, $urandom};
        cmd = r[$bits(t_blr_in)-1:0];
        return cmd;
    endfunction

    function automatic t_blr_in mk_start(input int xs, input int ys, input int xe,
                                         input int ye, input logic ink);
        t_blr_in cmd;
        cmd.op      = OP_START;
        cmd.x_start = xs[7:0];
        cmd.y_start = ys[7:0];
        cmd.x_end   = xe[7:0];
        cmd.y_end   = ye[7:0];
        cmd.ink     = ink;
        return cmd;
    endfunction

    function automatic t_blr_in mk_step();
        t_blr_in cmd;
        cmd    = '1;
        cmd.op = OP_STEP;
        return cmd;
    endfunction

    function automatic t_blr_out mk_pixel(input int x, input int y, input logic ink,
                                          input logic on, input int byte_idx,
                                          input int bit_pos, input logic last);
        t_blr_out px;
        px.pixel_valid  = 1'b1;
        px.pixel_x      = x[7:0];
        px.pixel_y      = y[7:0];
        px.pixel_ink    = ink;
        px.on_screen    = on;
        px.byte_index   = byte_idx[9:0];
        px.bit_position = bit_pos[2:0];
        px.last         = last;
        return px;
    endfunction

    function automatic t_row directed_row(input int idx);
        unique case (idx)
            0:  return '{mk_step(), 1'b1, '0};
            1:  return '{mk_start(5, 5, 5, 5, 1'b1), 1'b1,
                         mk_pixel(5, 5, 1'b1, 1'b1, 5, 5, 1'b1)};
            2:  return '{mk_step(), 1'b1, '0};
            3:  return '{mk_start(255, 255, 250, 0, 1'b0), 1'b1,
                         mk_pixel(255, 255, 1'b0, 1'b0, 0, 0, 1'b0)};
            7:  return '{mk_start(0, 0, 127, 63, 1'b1), 1'b1,
                         mk_pixel(0, 0, 1'b1, 1'b1, 0, 0, 1'b0)};
            10: return '{mk_start(127, 63, 0, 0, 1'b1), 1'b1,
                         mk_pixel(127, 63, 1'b1, 1'b1, 1023, 7, 1'b0)};
            13: return '{mk_start(10, 20, 11, 20, 1'b0), 1'b1,
                         mk_pixel(10, 20, 1'b0, 1'b1, 266, 4, 1'b0)};
            15: return '{mk_step(), 1'b1, '0};
            16: return '{mk_start(3, 0, 4, 9, 1'b1), 1'b0, '0};
            21: return '{mk_start(0, 200, 255, 0, 1'b1), 1'b1,
                         mk_pixel(0, 200, 1'b1, 1'b0, 0, 0, 1'b0)};
            24: return '{mk_start(128, 64, 128, 64, 1'b0), 1'b1,
                         mk_pixel(128, 64, 1'b0, 1'b0, 0, 0, 1'b1)};
            default: return '{mk_step(), 1'b0, '0};
        endcase
    endfunction

    function automatic int near(input int c);
        int v;
        v = c + $urandom_range(0, 24) - 12;
        return (v < 0) ? 0 : (v > 255) ? 255 : v;
    endfunction

    task automatic send_beat(input t_blr_in cmd, input logic typed, input t_blr_out want);
        int       gap;
        t_blr_out px;
        calm = ((sent / 48) % 4) == 3;
        gap  = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= cmd;
        do @(posedge i_clk); while (!in_if.ready);
        px = next_pixel(cmd);
        pending_pixels.push_back(typed ? want : px);
        sent++;
        if (cmd.op == OP_START) begin
            lines_started++;
        end
    endtask

    task automatic send_step();
        t_blr_in cmd;
        cmd    = rand_cmd();
        cmd.op = OP_STEP;
        send_beat(cmd, 1'b0, '0);
    endtask

    task automatic drain_pixels();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_pixels.size() != 0);
    endtask

    task automatic draw_line();
        int      xs, ys, xe, ye, len, steps;
        t_blr_in cmd;
        if ($urandom_range(0, 15) == 0) begin
            xs = $urandom_range(0, 255);
            ys = $urandom_range(0, 255);
            xe = $urandom_range(0, 255);
            ye = $urandom_range(0, 255);
        end else begin
            xs = $urandom_range(0, 140);
            ys = $urandom_range(0, 72);
            xe = near(xs);
            ye = near(ys);
        end
        cmd = mk_start(xs, ys, xe, ye, 1'($urandom));
        send_beat(cmd, 1'b0, '0);
        len = (xe > xs) ? xe - xs : xs - xe;
        if (((ye > ys) ? ye - ys : ys - ye) > len) begin
            len = (ye > ys) ? ye - ys : ys - ye;
        end
        steps = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len)
                                            : len + $urandom_range(0, 2);
        repeat (steps) begin
            if (sent < TOTAL_ITEMS) begin
                send_step();
            end
        end
    endtask

    task automatic check_pixel(input t_blr_out got);
        t_blr_out want;
        if (got.pixel_valid) begin
            pixels_seen++;
            line_ends += got.last;
            clipped   += !got.on_screen;
        end else begin
            idle_steps++;
        end
        if (pending_pixels.size() == 0) begin
            if (failures < MAX_REPORTS) begin
                $display("unexpected pixel beat %p", got);
            end
            failures++;
            return;
        end
        want = pending_pixels.pop_front();
        if (got.pixel_valid !== want.pixel_valid || got.pixel_x !== want.pixel_x ||
            got.pixel_y !== want.pixel_y || got.pixel_ink !== want.pixel_ink ||
            got.on_screen !== want.on_screen || got.byte_index !== want.byte_index ||
            got.bit_position !== want.bit_position || got.last !== want.last) begin
            if (failures < MAX_REPORTS) begin
                $display("pixel mismatch at cycle %0d", cycles);
                $display("  expected %p", want);
                $display("  actual   %p", got);
            end
            failures++;
        end
    endtask

    initial begin
        int stall;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            check_pixel(out_if.data);
        end
    end

    initial begin
        t_row row;
        bit   pressed;
        t_blr_in cmd;
        pressed     = 1'b0;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++) begin
            row = directed_row(i);
            send_beat(row.cmd, row.typed, row.want);
        end
        drain_pixels();

        while (sent < TOTAL_ITEMS) begin
            if (!pressed && sent >= TOTAL_ITEMS / 2) begin
                drain_pixels();
                pressed = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                cmd = rand_cmd();
                send_beat(cmd, 1'b0, '0);
            end else begin
                draw_line();
            end
        end

        drain_pixels();
        repeat (8) @(posedge i_clk);

        $display("Ran %0d commands over %0d line starts in %0d cycles.",
                 sent, lines_started, cycles);
        $display("Pixels %0d (line ends %0d, clipped %0d), idle steps %0d, failures %0d.",
                 pixels_seen, line_ends, clipped, idle_steps, failures);
        if (failures == 0 && pending_pixels.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
